// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the RTL, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at a clock edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/jdbp_pkg.sv
// ----------------------------------------------------------------------------
// JUMBF description box parser package
// Region codes, item and result types, and the optional-region search.
// ----------------------------------------------------------------------------
package jdbp_pkg;

    typedef enum logic [3:0] {
        REG_LENGTH  = 4'd0,
        REG_TYPE    = 4'd1,
        REG_EXTLEN  = 4'd2,
        REG_UUID    = 4'd3,
        REG_TOGGLES = 4'd4,
        REG_LABEL   = 4'd5,
        REG_ID      = 4'd6,
        REG_HASH    = 4'd7,
        REG_PRIVATE = 4'd8,
        REG_IGNORED = 4'd9
    } t_region;

    localparam logic [31:0] EXP_TYPE_RESET = 32'h6A756D64;
    localparam logic [31:0] LEN_EXTENDED   = 32'd1;
    localparam logic [7:0]  LABEL_END      = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_item;

    typedef struct packed {
        t_region     region;
        logic [15:0] offset;
        logic [7:0]  byte_out;
        logic [63:0] field_value;
        logic        value_done;
        logic [7:0]  toggles_out;
        logic [63:0] box_size;
        logic        type_error;
    } t_result;

    // First optional region after cur whose toggle bit is set.
    function automatic t_region next_present(t_region cur, logic [7:0] tog);
        t_region r;
        r = REG_IGNORED;
        for (int k = 8; k >= 5; k--) begin
            if (k > int'(cur) && tog[k-4]) begin
                r = t_region'(4'(k));
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/jdbp_ifs.sv
// ----------------------------------------------------------------------------
// JUMBF description box parser channels
// Valid/ready channels for input bytes, results and the type register.
// ----------------------------------------------------------------------------
interface jdbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, data_byte, frame_start, input ready);
    modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface jdbp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  region;
    logic [15:0] offset;
    logic [7:0]  byte_out;
    logic [63:0] field_value;
    logic        value_done;
    logic [7:0]  toggles_out;
    logic [63:0] box_size;
    logic        type_error;

    modport source (output valid, region, offset, byte_out, field_value, value_done,
                    toggles_out, box_size, type_error, input ready);
    modport sink   (input valid, region, offset, byte_out, field_value, value_done,
                    toggles_out, box_size, type_error, output ready);
endinterface

interface jdbp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/jdbp_parser.sv
// ----------------------------------------------------------------------------
// JUMBF description box parser core
// Region state registers and the combinational byte step.
// ----------------------------------------------------------------------------
module jdbp_parser #(
    parameter int HASH_BYTES  = 32,
    parameter int OFFSET_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  jdbp_pkg::t_item  i_item,
    input  logic [31:0]      i_expected_type,
    output jdbp_pkg::t_result o_result
);
    import jdbp_pkg::*;

    localparam logic [OFFSET_BITS-1:0] HASH_LAST = OFFSET_BITS'(HASH_BYTES - 1);
    localparam logic [OFFSET_BITS-1:0] LAST_OF4  = OFFSET_BITS'(3);
    localparam logic [OFFSET_BITS-1:0] LAST_OF8  = OFFSET_BITS'(7);
    localparam logic [OFFSET_BITS-1:0] LAST_OF16 = OFFSET_BITS'(15);

    t_region                r_region,  n_region,  c_region,  nxt;
    logic [OFFSET_BITS-1:0] r_offset,  n_offset,  c_offset;
    logic [63:0]            r_acc,     n_acc,     c_acc,     shifted;
    logic [31:0]            r_length,  n_length,  c_length;
    logic [7:0]             r_toggles, n_toggles, c_toggles;
    logic [63:0]            r_size,    n_size,    c_size;
    logic                   r_error,   n_error,   c_error;
    logic                   done, adv;
    logic [OFFSET_BITS+15:0] off_ext;
    logic [7:0]             b;

    assign b       = i_item.data_byte;
    assign shifted = {c_acc[55:0], b};
    assign off_ext = {16'b0, c_offset};

    always_comb begin
        if (i_item.frame_start) begin
            c_region  = REG_LENGTH;
            c_offset  = '0;
            c_acc     = '0;
            c_length  = '0;
            c_toggles = '0;
            c_size    = '0;
            c_error   = 1'b0;
        end else begin
            c_region  = r_region;
            c_offset  = r_offset;
            c_acc     = r_acc;
            c_length  = r_length;
            c_toggles = r_toggles;
            c_size    = r_size;
            c_error   = r_error;
        end

        n_acc     = c_acc;
        n_length  = c_length;
        n_toggles = c_toggles;
        n_size    = c_size;
        n_error   = c_error;
        nxt       = c_region;
        done      = 1'b0;
        adv       = 1'b0;

        case (c_region)
            REG_LENGTH: begin
                n_acc = shifted;
                if (c_offset >= LAST_OF4) begin
                    done     = 1'b1;
                    adv      = 1'b1;
                    n_length = shifted[31:0];
                    n_size   = (shifted[31:0] == LEN_EXTENDED) ? 64'd0 : {32'b0, shifted[31:0]};
                    nxt      = REG_TYPE;
                end
            end
            REG_TYPE: begin
                n_acc = shifted;
                if (c_offset >= LAST_OF4) begin
                    done = 1'b1;
                    adv  = 1'b1;
                    if (shifted[31:0] != i_expected_type) begin
                        n_error = 1'b1;
                        nxt     = REG_IGNORED;
                    end else begin
                        nxt = (c_length == LEN_EXTENDED) ? REG_EXTLEN : REG_UUID;
                    end
                end
            end
            REG_EXTLEN: begin
                n_acc = shifted;
                if (c_offset >= LAST_OF8) begin
                    done   = 1'b1;
                    adv    = 1'b1;
                    n_size = shifted;
                    nxt    = REG_UUID;
                end
            end
            REG_UUID: begin
                if (c_offset >= LAST_OF16) begin
                    adv = 1'b1;
                    nxt = REG_TOGGLES;
                end
            end
            REG_TOGGLES: begin
                n_toggles = b;
                adv       = 1'b1;
                nxt       = next_present(REG_TOGGLES, b);
            end
            REG_LABEL: begin
                if (b == LABEL_END) begin
                    adv = 1'b1;
                    nxt = next_present(REG_LABEL, c_toggles);
                end
            end
            REG_ID: begin
                n_acc = shifted;
                if (c_offset >= LAST_OF4) begin
                    done = 1'b1;
                    adv  = 1'b1;
                    nxt  = next_present(REG_ID, c_toggles);
                end
            end
            REG_HASH: begin
                if (c_offset >= HASH_LAST) begin
                    adv = 1'b1;
                    nxt = next_present(REG_HASH, c_toggles);
                end
            end
            default: begin
            end
        endcase

        if (adv) begin
            n_region = nxt;
            n_offset = '0;
            n_acc    = '0;
        end else begin
            n_region = c_region;
            n_offset = (&c_offset) ? c_offset : c_offset + 1'b1;
        end

        o_result.region      = c_region;
        o_result.offset      = off_ext[15:0];
        o_result.byte_out    = b;
        o_result.field_value = done ? shifted : 64'd0;
        o_result.value_done  = done;
        o_result.toggles_out = n_toggles;
        o_result.box_size    = n_size;
        o_result.type_error  = n_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region  <= REG_LENGTH;
            r_offset  <= '0;
            r_acc     <= '0;
            r_length  <= '0;
            r_toggles <= '0;
            r_size    <= '0;
            r_error   <= 1'b0;
        end else if (i_accept) begin
            r_region  <= n_region;
            r_offset  <= n_offset;
            r_acc     <= n_acc;
            r_length  <= n_length;
            r_toggles <= n_toggles;
            r_size    <= n_size;
            r_error   <= n_error;
        end
    end

endmodule

// File: rtl/jdbp_out_stage.sv
// ----------------------------------------------------------------------------
// JUMBF description box parser result register
// Holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module jdbp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  jdbp_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_can_load,
    output jdbp_pkg::t_result o_result
);
    import jdbp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: rtl/jumbf_description_box_parser_top.sv
// ----------------------------------------------------------------------------
// JUMBF description box parser
// Tags each byte of a description box with its region and offset.
//
//   channel  dir  payload                                     handshake
//   i_in     in   data_byte, frame_start                      valid/ready
//   o_res    out  region, offset, byte_out, field_value,      valid/ready
//                 value_done, toggles_out, box_size, type_error
//   i_cfg    in   data (expected box type)                    valid/ready
//
// One item per cycle while the sink takes results; each result appears in the cycle after its byte is taken.
// The result register follows the combinational region step.
// i_in.ready is low only while a held result is not taken by the sink.
// Synchronous active-low reset; expected type resets to 'jumd'.
// i_cfg is always ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jumbf_description_box_parser_top #(
    parameter int HASH_BYTES  = 32,
    parameter int OFFSET_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jdbp_in_if.sink    i_in,
    jdbp_out_if.source o_res,
    jdbp_cfg_if.sink   i_cfg
);
    import jdbp_pkg::*;

    logic [31:0] r_expected_type;
    t_item       item;
    t_result     step_result;
    t_result     held_result;
    logic        can_load;
    logic        accept;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_type <= EXP_TYPE_RESET;
        end else if (i_cfg.valid) begin
            r_expected_type <= i_cfg.data;
        end
    end

    assign item.data_byte   = i_in.data_byte;
    assign item.frame_start = i_in.frame_start;
    assign i_in.ready       = can_load;
    assign accept           = i_in.valid && can_load;

    jdbp_parser #(
        .HASH_BYTES  (HASH_BYTES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_item          (item),
        .i_expected_type (r_expected_type),
        .o_result        (step_result)
    );

    jdbp_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_result   (step_result),
        .i_ready    (o_res.ready),
        .o_valid    (o_res.valid),
        .o_can_load (can_load),
        .o_result   (held_result)
    );

    assign o_res.region      = held_result.region;
    assign o_res.offset      = held_result.offset;
    assign o_res.byte_out    = held_result.byte_out;
    assign o_res.field_value = held_result.field_value;
    assign o_res.value_done  = held_result.value_done;
    assign o_res.toggles_out = held_result.toggles_out;
    assign o_res.box_size    = held_result.box_size;
    assign o_res.type_error  = held_result.type_error;

    `ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, accept, o_res.valid, "accepted item gave no result")
    `ASSERT_ALWAYS(a_done_region, i_clk, i_rst_n, !(o_res.valid && o_res.value_done) || held_result.region == REG_LENGTH || held_result.region == REG_TYPE || held_result.region == REG_EXTLEN || held_result.region == REG_ID, "value done outside a numeric field")
    `ASSERT_ALWAYS(a_value_zero, i_clk, i_rst_n, !o_res.valid || o_res.value_done || o_res.field_value == 64'd0, "field value set without done")
    `ASSERT_ALWAYS(a_error_region, i_clk, i_rst_n, !(o_res.valid && o_res.type_error) || held_result.region == REG_TYPE || held_result.region == REG_IGNORED, "type error outside type or ignored region")

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// JUMBF description box parser testbench
// Feeds byte streams of description boxes through the valid/ready input,
// tags each byte with an in-bench copy of the region parser and compares every
// result field by field. A typed table of directed bytes comes first, then
// random well-formed, mistyped, cut and noisy boxes under changing back-pressure
// and expected type codes.
// ----------------------------------------------------------------------------
module testbench;
    import jdbp_pkg::*;

    localparam int          HASH_LEN       = 32;
    localparam logic [15:0] OFFSET_TOP     = 16'hFFFF;
    localparam int          RESULT_LATENCY = 1;
    localparam int          STALL_LIMIT    = 4000;
    localparam int          HOLD_CYCLES    = 80;
    localparam int          LONG_PRIVATE   = 120;
    localparam int          PHASE_ITEMS    = 450;
    localparam int          MAX_REPORTS    = 10;

    typedef enum {BOX_GOOD, BOX_BAD_TYPE, BOX_CUT, BOX_NOISE} t_box_kind;

    typedef struct {
        t_item   it;
        logic    chk;
        t_result want;
    } t_row;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    jdbp_in_if  in_ch ();
    jdbp_out_if res_ch ();
    jdbp_cfg_if cfg_ch ();

    jumbf_description_box_parser_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // parser copy
    t_region     p_region;
    logic [15:0] p_offset;
    logic [63:0] p_acc;
    logic [31:0] p_length;
    logic [7:0]  p_toggles;
    logic [63:0] p_size;
    logic        p_error;
    logic [31:0] p_type;

    t_result pending_tags[$];
    t_row    dir_rows[$];
    t_item   frame_q[$];
    int      mismatches  = 0;
    int      idle_cycles = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    logic    rx_rand     = 1'b0;
    logic    rx_hold     = 1'b0;
    logic    pressure_go = 1'b0;
    logic    row_chk     = 1'b0;
    t_result row_want    = '0;
    logic [31:0] cur_type = EXP_TYPE_RESET;

    assign res_ch.ready = rx_rand & ~rx_hold;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic t_region following_region(t_region cur, logic [7:0] tog);
        for (int k = int'(cur) + 1; k <= int'(REG_PRIVATE); k++) begin
            if (k >= int'(REG_LABEL) && tog[k-4]) begin
                return t_region'(k);
            end
        end
        return REG_IGNORED;
    endfunction

    task automatic clear_tag_state();
        p_region  = REG_LENGTH;
        p_offset  = '0;
        p_acc     = '0;
        p_length  = '0;
        p_toggles = '0;
        p_size    = '0;
        p_error   = 1'b0;
    endtask

    task automatic tag_byte(input t_item it, output t_result tag);
        logic [7:0]  b;
        t_region     cur;
        t_region     nxt;
        logic [15:0] off;
        logic        done;
        logic        adv;
        logic [63:0] val;
        if (it.frame_start) begin
            clear_tag_state();
        end
        b    = it.data_byte;
        cur  = p_region;
        off  = p_offset;
        nxt  = cur;
        done = 1'b0;
        adv  = 1'b0;
        val  = '0;
        case (cur)
            REG_LENGTH: begin
                p_acc = {p_acc[55:0], b};
                if (off >= 16'd3) begin
                    done     = 1'b1;
                    val      = p_acc;
                    p_length = p_acc[31:0];
                    p_size   = (p_length == LEN_EXTENDED) ? 64'd0 : {32'd0, p_length};
                    nxt      = REG_TYPE;
                    adv      = 1'b1;
                end
            end
            REG_TYPE: begin
                p_acc = {p_acc[55:0], b};
                if (off >= 16'd3) begin
                    done = 1'b1;
                    val  = p_acc;
                    if (p_acc[31:0] != p_type) begin
                        p_error = 1'b1;
                        nxt     = REG_IGNORED;
                    end else begin
                        nxt = (p_length == LEN_EXTENDED) ? REG_EXTLEN : REG_UUID;
                    end
                    adv = 1'b1;
                end
            end
            REG_EXTLEN: begin
                p_acc = {p_acc[55:0], b};
                if (off >= 16'd7) begin
                    done   = 1'b1;
                    val    = p_acc;
                    p_size = p_acc;
                    nxt    = REG_UUID;
                    adv    = 1'b1;
                end
            end
            REG_UUID: begin
                if (off >= 16'd15) begin
                    nxt = REG_TOGGLES;
                    adv = 1'b1;
                end
            end
            REG_TOGGLES: begin
                p_toggles = b;
                nxt       = following_region(REG_TOGGLES, b);
                adv       = 1'b1;
            end
            REG_LABEL: begin
                if (b == LABEL_END) begin
                    nxt = following_region(REG_LABEL, p_toggles);
                    adv = 1'b1;
                end
            end
            REG_ID: begin
                p_acc = {p_acc[55:0], b};
                if (off >= 16'd3) begin
                    done = 1'b1;
                    val  = p_acc;
                    nxt  = following_region(REG_ID, p_toggles);
                    adv  = 1'b1;
                end
            end
            REG_HASH: begin
                if (off >= 16'(HASH_LEN - 1)) begin
                    nxt = following_region(REG_HASH, p_toggles);
                    adv = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (adv) begin
            p_region = nxt;
            p_offset = '0;
            p_acc    = '0;
        end else if (p_offset != OFFSET_TOP) begin
            p_offset = p_offset + 16'd1;
        end
        tag.region      = cur;
        tag.offset      = off;
        tag.byte_out    = b;
        tag.field_value = done ? val : 64'd0;
        tag.value_done  = done;
        tag.toggles_out = p_toggles;
        tag.box_size    = p_size;
        tag.type_error  = p_error;
    endtask

    task automatic check_tag(input t_result got);
        t_result want;
        if (pending_tags.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("result with no tag pending: region %0d offset %0d byte %h",
                         got.region, got.offset, got.byte_out);
            end
        end else begin
            want = pending_tags.pop_front();
            if (got.region !== want.region || got.offset !== want.offset ||
                got.byte_out !== want.byte_out || got.field_value !== want.field_value ||
                got.value_done !== want.value_done || got.toggles_out !== want.toggles_out ||
                got.box_size !== want.box_size || got.type_error !== want.type_error) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch exp/got rg %0d/%0d off %0d/%0d b %h/%h d %b/%b e %b/%b",
                             want.region, got.region, want.offset, got.offset,
                             want.byte_out, got.byte_out, want.value_done, got.value_done,
                             want.type_error, got.type_error);
                    $display("  value %h/%h toggles %h/%h size %h/%h",
                             want.field_value, got.field_value, want.toggles_out,
                             got.toggles_out, want.box_size, got.box_size);
                end
            end
        end
    endtask

    always @(posedge clk) begin
        t_result got;
        t_result pred;
        t_item   it;
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.region      = t_region'(res_ch.region);
                got.offset      = res_ch.offset;
                got.byte_out    = res_ch.byte_out;
                got.field_value = res_ch.field_value;
                got.value_done  = res_ch.value_done;
                got.toggles_out = res_ch.toggles_out;
                got.box_size    = res_ch.box_size;
                got.type_error  = res_ch.type_error;
                check_tag(got);
            end
            if (in_ch.valid && in_ch.ready) begin
                it.data_byte   = in_ch.data_byte;
                it.frame_start = in_ch.frame_start;
                tag_byte(it, pred);
                pending_tags.insert(pending_tags.size(), row_chk ? row_want : pred);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                p_type = cfg_ch.data;
            end
        end
    end

    always @(posedge clk) begin
        rx_rand <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic drive_byte(input t_item it, input logic chk, input t_result want);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= it.data_byte;
        in_ch.frame_start <= it.frame_start;
        row_chk           <= chk;
        row_want          <= want;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic add_plain(input logic [7:0] b, input logic fs);
        t_row r;
        r.it.data_byte   = b;
        r.it.frame_start = fs;
        r.chk            = 1'b0;
        r.want           = '0;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic add_checked(input logic [7:0] b, input logic fs, input t_region rg,
                               input logic [15:0] off, input logic [63:0] fv,
                               input logic done, input logic [63:0] box, input logic err);
        t_row r;
        r.it.data_byte   = b;
        r.it.frame_start = fs;
        r.chk            = 1'b1;
        r.want.region      = rg;
        r.want.offset      = off;
        r.want.byte_out    = b;
        r.want.field_value = fv;
        r.want.value_done  = done;
        r.want.toggles_out = 8'h00;
        r.want.box_size    = box;
        r.want.type_error  = err;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic put_byte(input logic [7:0] b);
        t_item it;
        it.data_byte   = b;
        it.frame_start = 1'b0;
        frame_q.insert(frame_q.size(), it);
    endtask

    task automatic put_word(input logic [63:0] v, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--) begin
            put_byte(v[8*i +: 8]);
        end
    endtask

    task automatic make_box(input t_box_kind kind, input int priv_len);
        logic [31:0] len;
        logic [31:0] typ;
        logic [7:0]  tog;
        int          n;
        frame_q.delete();
        if (kind == BOX_NOISE) begin
            repeat ($urandom_range(12, 1)) begin
                put_byte(8'($urandom_range(255)));
                frame_q[frame_q.size()-1].frame_start = ($urandom_range(7) == 0);
            end
        end else begin
            case ($urandom_range(5))
                0:       len = LEN_EXTENDED;
                1:       len = 32'd0;
                2:       len = 32'hFFFF_FFFF;
                3:       len = $urandom;
                default: len = $urandom_range(400, 26);
            endcase
            typ = cur_type;
            if (kind == BOX_BAD_TYPE) begin
                typ = cur_type ^ ($urandom_range(1) ? (32'd1 << $urandom_range(31))
                                                    : ($urandom | 32'd1));
            end
            put_word({32'd0, len}, 4);
            put_word({32'd0, typ}, 4);
            if (len == LEN_EXTENDED) begin
                put_word($urandom_range(3) == 0 ? 64'hFFFF_FFFF_FFFF_FFFF
                                                : {$urandom, $urandom}, 8);
            end
            repeat (16) put_byte(8'($urandom_range(255)));
            tog = 8'($urandom_range(255));
            if (priv_len >= 0) begin
                tog = tog | 8'h10;
            end
            put_byte(tog);
            if (tog[1]) begin
                repeat ($urandom_range(12)) put_byte(8'($urandom_range(255, 1)));
                put_byte(LABEL_END);
            end
            if (tog[2]) begin
                put_word({32'd0, $urandom}, 4);
            end
            if (tog[3]) begin
                repeat (HASH_LEN) put_byte(8'($urandom_range(255)));
            end
            if (tog[4]) begin
                n = (priv_len >= 0) ? priv_len : $urandom_range(20);
                repeat (n) put_byte(8'($urandom_range(255)));
            end
            repeat ($urandom_range(3)) put_byte(8'($urandom_range(255)));
            frame_q[0].frame_start = 1'b1;
            if (kind == BOX_CUT) begin
                n       = $urandom_range(frame_q.size() - 1);
                frame_q = frame_q[0:n];
            end
        end
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) begin
            drive_byte(frame_q[i], 1'b0, '0);
        end
    endtask

    task automatic write_type(input logic [31:0] v);
        in_ch.valid <= 1'b0;
        repeat (RESULT_LATENCY + 1) @(posedge clk);
        while (pending_tags.size() != 0) @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_type = v;
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input logic [31:0] v,
                             input logic long_run);
        int        sent;
        int        pick;
        t_box_kind kind;
        write_type(v);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        if (long_run) begin
            pressure_go = 1'b1;
            make_box(BOX_GOOD, LONG_PRIVATE);
            send_frame();
        end
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            kind = (pick < 70) ? BOX_GOOD : (pick < 80) ? BOX_BAD_TYPE :
                   (pick < 90) ? BOX_CUT : BOX_NOISE;
            make_box(kind, -1);
            send_frame();
            sent += frame_q.size();
        end
    endtask

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.data_byte   <= 8'h00;
        in_ch.frame_start <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= 32'd0;
        p_type = EXP_TYPE_RESET;
        clear_tag_state();

        add_checked(8'hFF, 1'b0, REG_LENGTH, 16'd0, 64'd0, 1'b0, 64'd0, 1'b0);
        add_plain(8'hFF, 1'b0);
        add_plain(8'hFF, 1'b0);
        add_checked(8'hFF, 1'b0, REG_LENGTH, 16'd3, 64'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF, 1'b0);
        add_plain(8'h00, 1'b0);
        add_plain(8'h00, 1'b0);
        add_plain(8'h00, 1'b0);
        add_checked(8'h00, 1'b0, REG_TYPE, 16'd3, 64'd0, 1'b1, 64'hFFFF_FFFF, 1'b1);
        add_checked(8'h5A, 1'b0, REG_IGNORED, 16'd0, 64'd0, 1'b0, 64'hFFFF_FFFF, 1'b1);
        add_checked(8'h00, 1'b1, REG_LENGTH, 16'd0, 64'd0, 1'b0, 64'd0, 1'b0);
        add_plain(8'h00, 1'b0);
        add_plain(8'h00, 1'b0);
        add_checked(8'h01, 1'b0, REG_LENGTH, 16'd3, 64'd1, 1'b1, 64'd0, 1'b0);
        add_plain(8'h6A, 1'b0);
        add_plain(8'h75, 1'b0);
        add_plain(8'h6D, 1'b0);
        add_checked(8'h64, 1'b0, REG_TYPE, 16'd3, {32'd0, EXP_TYPE_RESET}, 1'b1, 64'd0, 1'b0);
        repeat (7) add_plain(8'hFF, 1'b0);
        add_checked(8'hFF, 1'b0, REG_EXTLEN, 16'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                    64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_checked(8'h80, 1'b1, REG_LENGTH, 16'd0, 64'd0, 1'b0, 64'd0, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 24;
        rx_idle_pct <= 53;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            drive_byte(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].want);
        end

        run_phase(24, 53, 32'h0000_0000, 1'b0);
        run_phase(53, 24, 32'hFFFF_FFFF, 1'b0);
        run_phase(0, 0, $urandom, 1'b1);
        run_phase(0, 0, EXP_TYPE_RESET, 1'b0);

        in_ch.valid <= 1'b0;
        repeat (RESULT_LATENCY + 1) @(posedge clk);
        while (pending_tags.size() != 0) @(posedge clk);
        repeat (RESULT_LATENCY + 4) @(posedge clk);
        if (pending_tags.size() != 0) begin
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
